>>> design/preemptive_tick_scheduler_unit_assert.svh
// assertion macros used by the scheduler checker
`ifndef PREEMPTIVE_TICK_SCHEDULER_UNIT_ASSERT_SVH
`define PREEMPTIVE_TICK_SCHEDULER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/pts_pkg.sv
// widths and codes of the preemptive tick scheduler
package pts_pkg;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 4;
  localparam int PRIO_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  localparam logic [PADDR_W-3:0] REG_KEY_MODE = '0;

endpackage

>>> design/pts_ram.sv
// generic single-write, single-read ram with registered read data
module pts_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/preemptive_tick_scheduler_unit.sv
// preemptive tick scheduler: slot table in ram, serial scan, bit-serial metric subtractors
// a tick runs scan, drain, read, update and output; when the picked slot completes, a metric
// step runs between update and output; the scan reads one slot per cycle from the ram and the
// completion metrics come out of bit-serial subtractors, one bit per cycle
// load, clear and unused codes go straight to the output step
// reset clears loaded and started marks, the time counter and key_mode; no clearing pass
module preemptive_tick_scheduler_unit #(
  parameter int NUM_SLOTS = 16,
  parameter int TIME_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pts_pkg::PADDR_W-1:0]  paddr,
  input  logic [pts_pkg::PDATA_W-1:0]  pwdata,
  output logic [pts_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [pts_pkg::OP_W-1:0]     op_i,
  input  logic [pts_pkg::SLOT_W-1:0]   slot_i,
  input  logic [TIME_BITS-1:0]         burst_i,
  input  logic [TIME_BITS-1:0]         arrival_i,
  input  logic [pts_pkg::PRIO_W-1:0]   priority_req_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         ran_valid_o,
  output logic [pts_pkg::SLOT_W-1:0]   ran_slot_o,
  output logic                         finished_o,
  output logic [TIME_BITS-1:0]         finish_time_o,
  output logic [TIME_BITS-1:0]         response_time_o,
  output logic [TIME_BITS-1:0]         turnaround_time_o,
  output logic [TIME_BITS-1:0]         waiting_time_o,
  output logic                         all_done_o,
  output logic [TIME_BITS-1:0]         current_time_o
);
  import pts_pkg::*;

  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int EXT_W     = IDX_W + SLOT_W;
  localparam int BIT_W     = $clog2(TIME_BITS);
  localparam int WORD_W    = 4 * TIME_BITS + PRIO_W;
  localparam int FS_LSB    = 0;
  localparam int REM_LSB   = TIME_BITS;
  localparam int PRIO_LSB  = 2 * TIME_BITS;
  localparam int ARR_LSB   = 2 * TIME_BITS + PRIO_W;
  localparam int BURST_LSB = 3 * TIME_BITS + PRIO_W;

  localparam logic [IDX_W-1:0]     LAST_IDX = IDX_W'(NUM_SLOTS - 1);
  localparam logic [BIT_W-1:0]     LAST_BIT = BIT_W'(TIME_BITS - 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0] ONE_T    = TIME_BITS'(1);
  localparam logic [IDX_W-1:0]     ONE_IDX  = IDX_W'(1);
  localparam logic [BIT_W-1:0]     ONE_BIT  = BIT_W'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_UPD   = 3'd4;
  localparam logic [2:0] ST_METR  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  // control state
  logic [2:0]           state_q;
  logic [IDX_W-1:0]     cnt_q;
  logic                 eval_q;
  logic [IDX_W-1:0]     eval_idx_q;
  logic                 found_q;
  logic [TIME_BITS-1:0] best_q;
  logic [IDX_W-1:0]     pick_q;
  logic [TIME_BITS-1:0] now_q;
  logic [NUM_SLOTS-1:0] live_q;
  logic [NUM_SLOTS-1:0] started_q;
  logic                 key_mode_q;
  logic                 ran_valid_q;
  logic                 finished_q;
  logic [BIT_W-1:0]     bit_q;
  logic                 out_valid_q;

  // serial datapath
  logic [TIME_BITS-1:0] sh_now_q, sh_fs_q, sh_arr_q, sh_burst_q;
  logic [TIME_BITS-1:0] resp_sr_q, tat_sr_q, wait_sr_q, fin_time_q;
  logic                 br_resp_q, br_tat_q, br_wait_q;

  // output word
  logic                 ran_valid_q2, finished_q2, all_done_q;
  logic [SLOT_W-1:0]    ran_slot_q;
  logic [TIME_BITS-1:0] finish_time_q, response_time_q, turnaround_time_q;
  logic [TIME_BITS-1:0] waiting_time_q, current_time_q;

  // ram
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [WORD_W-1:0]  wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [WORD_W-1:0]  rd_data;

  logic [TIME_BITS-1:0] rd_fs, rd_rem, rd_arr, rd_burst;
  logic [PRIO_W-1:0]    rd_prio;

  logic                 in_acc, cfg_wr;
  logic [EXT_W-1:0]     slot_ext, pick_ext;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic [TIME_BITS-1:0] key, rem_new, fs_eff, now_next;
  logic                 eligible, take, out_free;
  logic                 resp_bit, tat_bit, wait_bit;
  logic                 br_resp_n, br_tat_n, br_wait_n;

  pts_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_fs    = rd_data[FS_LSB +: TIME_BITS];
  assign rd_rem   = rd_data[REM_LSB +: TIME_BITS];
  assign rd_prio  = rd_data[PRIO_LSB +: PRIO_W];
  assign rd_arr   = rd_data[ARR_LSB +: TIME_BITS];
  assign rd_burst = rd_data[BURST_LSB +: TIME_BITS];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign slot_ext = EXT_W'(slot_i);
  assign slot_ok  = slot_ext < EXT_W'(NUM_SLOTS);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign pick_ext = EXT_W'(pick_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // scan compare: evaluates the word read in the cycle before
  assign key      = key_mode_q ? TIME_BITS'(rd_prio) : rd_rem;
  assign eligible = eval_q && live_q[eval_idx_q] && (rd_arr <= now_q);
  assign take     = eligible && (!found_q || (key < best_q));

  assign rem_new  = rd_rem - ONE_T;
  assign fs_eff   = started_q[pick_q] ? rd_fs : now_q;
  assign now_next = (now_q != TIME_MAX) ? (now_q + ONE_T) : now_q;

  // bit-serial subtractors, lsb first
  assign resp_bit  = sh_fs_q[0] ^ sh_arr_q[0] ^ br_resp_q;
  assign br_resp_n = (~sh_fs_q[0] & sh_arr_q[0]) | (~(sh_fs_q[0] ^ sh_arr_q[0]) & br_resp_q);
  assign tat_bit   = sh_now_q[0] ^ sh_arr_q[0] ^ br_tat_q;
  assign br_tat_n  = (~sh_now_q[0] & sh_arr_q[0]) | (~(sh_now_q[0] ^ sh_arr_q[0]) & br_tat_q);
  assign wait_bit  = tat_bit ^ sh_burst_q[0] ^ br_wait_q;
  assign br_wait_n = (~tat_bit & sh_burst_q[0]) | (~(tat_bit ^ sh_burst_q[0]) & br_wait_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_q;
    wr_data = {rd_burst, rd_arr, rd_prio, rem_new, fs_eff};
    rd_addr = (state_q == ST_SCAN) ? cnt_q : pick_q;
    if (state_q == ST_IDLE && in_acc && op_i == OP_LOAD && slot_ok) begin
      wr_en   = 1'b1;
      wr_addr = slot_idx;
      wr_data = {burst_i, arrival_i, priority_req_i, burst_i, {TIME_BITS{1'b0}}};
    end else if (state_q == ST_UPD && found_q) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      eval_q      <= 1'b0;
      eval_idx_q  <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      pick_q      <= '0;
      now_q       <= '0;
      live_q      <= '0;
      started_q   <= '0;
      key_mode_q  <= 1'b0;
      ran_valid_q <= 1'b0;
      finished_q  <= 1'b0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      eval_q     <= (state_q == ST_SCAN);
      eval_idx_q <= cnt_q;
      if (take) begin
        found_q <= 1'b1;
        best_q  <= key;
        pick_q  <= eval_idx_q;
      end
      if (cfg_wr && paddr[PADDR_W-1:2] == REG_KEY_MODE) begin
        key_mode_q <= pwdata[0];
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ran_valid_q <= 1'b0;
            finished_q  <= 1'b0;
            case (op_i)
              OP_LOAD: begin
                if (slot_ok) begin
                  live_q[slot_idx]    <= (burst_i != '0);
                  started_q[slot_idx] <= 1'b0;
                end
                state_q <= ST_OUT;
              end
              OP_TICK: begin
                cnt_q   <= '0;
                found_q <= 1'b0;
                state_q <= ST_SCAN;
              end
              OP_CLEAR: begin
                live_q    <= '0;
                started_q <= '0;
                now_q     <= '0;
                state_q   <= ST_OUT;
              end
              default: begin
                state_q <= ST_OUT;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (cnt_q == LAST_IDX) begin
            state_q <= ST_DRAIN;
          end else begin
            cnt_q <= cnt_q + ONE_IDX;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_UPD;
        end
        ST_UPD: begin
          now_q       <= now_next;
          ran_valid_q <= found_q;
          finished_q  <= found_q && (rem_new == '0);
          bit_q       <= '0;
          if (found_q) begin
            live_q[pick_q]    <= (rem_new != '0);
            started_q[pick_q] <= 1'b1;
          end
          state_q <= (found_q && rem_new == '0) ? ST_METR : ST_OUT;
        end
        ST_METR: begin
          if (bit_q == LAST_BIT) begin
            state_q <= ST_OUT;
          end else begin
            bit_q <= bit_q + ONE_BIT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // operand and result shift registers of the metric subtractors
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      sh_now_q   <= now_next;
      sh_fs_q    <= fs_eff;
      sh_arr_q   <= rd_arr;
      sh_burst_q <= rd_burst;
      fin_time_q <= now_next;
      br_resp_q  <= 1'b0;
      br_tat_q   <= 1'b0;
      br_wait_q  <= 1'b0;
    end else if (state_q == ST_METR) begin
      sh_now_q   <= sh_now_q >> 1;
      sh_fs_q    <= sh_fs_q >> 1;
      sh_arr_q   <= sh_arr_q >> 1;
      sh_burst_q <= sh_burst_q >> 1;
      resp_sr_q  <= {resp_bit, resp_sr_q[TIME_BITS-1:1]};
      tat_sr_q   <= {tat_bit, tat_sr_q[TIME_BITS-1:1]};
      wait_sr_q  <= {wait_bit, wait_sr_q[TIME_BITS-1:1]};
      br_resp_q  <= br_resp_n;
      br_tat_q   <= br_tat_n;
      br_wait_q  <= br_wait_n;
    end
  end

  // output word; a final borrow means the difference floors at zero
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      ran_valid_q2      <= ran_valid_q;
      ran_slot_q        <= ran_valid_q ? pick_ext[SLOT_W-1:0] : '0;
      finished_q2       <= finished_q;
      finish_time_q     <= finished_q ? fin_time_q : '0;
      response_time_q   <= (finished_q && !br_resp_q) ? resp_sr_q : '0;
      turnaround_time_q <= (finished_q && !br_tat_q) ? tat_sr_q : '0;
      waiting_time_q    <= (finished_q && !br_tat_q && !br_wait_q) ? wait_sr_q : '0;
      all_done_q        <= ~|live_q;
      current_time_q    <= now_q;
    end
  end

  assign in_stall_o        = (state_q != ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign ran_valid_o       = ran_valid_q2;
  assign ran_slot_o        = ran_slot_q;
  assign finished_o        = finished_q2;
  assign finish_time_o     = finish_time_q;
  assign response_time_o   = response_time_q;
  assign turnaround_time_o = turnaround_time_q;
  assign waiting_time_o    = waiting_time_q;
  assign all_done_o        = all_done_q;
  assign current_time_o    = current_time_q;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_KEY_MODE) ? PDATA_W'(key_mode_q) : '0;

endmodule

>>> design/pts_checker.sv
// port-level checker for the preemptive tick scheduler, bound to the top level
`include "preemptive_tick_scheduler_unit_assert.svh"

module pts_checker #(
  parameter int TIME_BITS = 16
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic                 ran_valid_o,
  input logic                 finished_o,
  input logic [TIME_BITS-1:0] response_time_o,
  input logic [TIME_BITS-1:0] turnaround_time_o,
  input logic [TIME_BITS-1:0] waiting_time_o,
  input logic [TIME_BITS-1:0] current_time_o
);

  // a stalled result word holds
  `PTS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(current_time_o), "stalled result word changed")

  // one word in flight: the block is busy right after taking a word
  `PTS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken while a word is in flight")

  // a new result frees the input side in the same cycle
  `PTS_ASSERT_NOW(a_free_on_result, $rose(out_valid_o), !in_stall_o, "input still stalled after result issued")

  // a completion comes from a slot that ran, with consistent metrics
  `PTS_ASSERT_NOW(a_metrics, out_valid_o && finished_o, ran_valid_o && (waiting_time_o <= turnaround_time_o) && (response_time_o <= turnaround_time_o), "completion metrics inconsistent")

endmodule

bind preemptive_tick_scheduler_unit pts_checker #(.TIME_BITS(TIME_BITS)) u_pts_checker (.*);
